// ===== hdl/ptba_pkg.sv =====
`timescale 1ns / 1ps

package ptba_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd512;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd512;

  // payload widths
  localparam int PIX_W = 8;
  localparam int POS_W = 10;

  // block queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic [PIX_W-1:0] value;
  } block_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } queue_status_t;

  typedef enum logic [1:0] {
    PH_TOP_LEFT     = 2'd0,
    PH_BOTTOM_LEFT  = 2'd1,
    PH_TOP_RIGHT    = 2'd2,
    PH_BOTTOM_RIGHT = 2'd3
  } phase_e;

endpackage

// ===== hdl/ptba_front.sv =====
`timescale 1ns / 1ps

module ptba_front #(
  parameter int MAX_WIDTH  = ptba_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ptba_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [ptba_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [ptba_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             pix_accept_i,
  input  logic [ptba_pkg::PIX_W-1:0]       pixel_value_i,
  output logic                             push_o,
  output ptba_pkg::block_t                 block_o
);
  import ptba_pkg::*;

  localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int DW0        = (CW > RW) ? CW + 1 : RW + 1;
  localparam int DIM_W      = (DW0 > CFG_DATA_W) ? DW0 : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] width_q, width_d;
  logic [CFG_DATA_W-1:0] height_q, height_d;
  logic [CW-1:0]         col_q, col_d;
  logic [RW-1:0]         row_q, row_d;
  logic [PIX_W-1:0]      left_q, left_d;
  logic [PIX_W:0]        above_q;
  logic [PIX_W:0]        line_mem [LINE_DEPTH];

  logic [DIM_W-1:0] fw_ext, fh_ext, w_dim, h_dim, col_ext, row_ext;
  logic [CW-1:0]    half_col;
  logic [AW-1:0]    line_idx;
  logic             cfg_hit, in_region, col_odd, row_odd;
  logic             line_wr, line_rd;
  logic [PIX_W:0]   pair_sum;
  logic [PIX_W+1:0] box_sum;
  logic [31:0]      top_row, left_col;

  always_comb begin
    fw_ext = DIM_W'(width_q);
    fh_ext = DIM_W'(height_q);
    if (fw_ext < DIM_W'(2)) begin
      w_dim = DIM_W'(2);
    end else if (fw_ext > DIM_W'(MAX_WIDTH)) begin
      w_dim = DIM_W'(MAX_WIDTH);
    end else begin
      w_dim = fw_ext;
    end
    if (fh_ext < DIM_W'(2)) begin
      h_dim = DIM_W'(2);
    end else if (fh_ext > DIM_W'(MAX_HEIGHT)) begin
      h_dim = DIM_W'(MAX_HEIGHT);
    end else begin
      h_dim = fh_ext;
    end
  end

  assign col_ext   = DIM_W'(col_q);
  assign row_ext   = DIM_W'(row_q);
  // odd trailing column / row fall outside
  assign in_region = (col_ext < {w_dim[DIM_W-1:1], 1'b0}) &&
                     (row_ext < {h_dim[DIM_W-1:1], 1'b0});
  assign col_odd   = col_q[0];
  assign row_odd   = row_q[0];
  assign half_col  = col_q >> 1;
  assign line_idx  = half_col[AW-1:0];

  assign pair_sum = {1'b0, left_q} + {1'b0, pixel_value_i};
  assign box_sum  = {1'b0, above_q} + {1'b0, pair_sum};
  assign line_wr  = pix_accept_i && in_region && col_odd && !row_odd;
  // fetch the pair above on the even pixel, ready by its odd partner
  assign line_rd  = pix_accept_i && in_region && !col_odd && row_odd;

  assign top_row  = 32'(row_q) - 32'd1;
  assign left_col = 32'(col_q) - 32'd1;

  assign push_o         = pix_accept_i && in_region && col_odd && row_odd;
  assign block_o.row    = top_row[POS_W-1:0];
  assign block_o.column = left_col[POS_W-1:0];
  assign block_o.value  = box_sum[PIX_W+1:2];

  assign cfg_hit = cfg_valid_i &&
                   (cfg_index_i == REG_FRAME_WIDTH || cfg_index_i == REG_FRAME_HEIGHT);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    left_d   = left_q;
    if (cfg_hit) begin
      if (cfg_index_i == REG_FRAME_WIDTH) begin
        width_d = cfg_data_i;
      end else begin
        height_d = cfg_data_i;
      end
      col_d  = '0;
      row_d  = '0;
      left_d = '0;
    end else if (pix_accept_i) begin
      if (in_region && !col_odd) begin
        left_d = pixel_value_i;
      end
      if (col_ext + DIM_W'(1) >= w_dim) begin
        col_d = '0;
        if (row_ext + DIM_W'(1) >= h_dim) begin
          row_d = '0;
        end else begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      left_q   <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_wr) begin
      line_mem[line_idx] <= pair_sum;
    end
    if (line_rd) begin
      above_q <= line_mem[line_idx];
    end
  end

endmodule

// ===== hdl/ptba_queue.sv =====
`timescale 1ns / 1ps

module ptba_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  ptba_pkg::block_t          block_i,
  input  logic                      pop_i,
  output ptba_pkg::block_t          head_o,
  output ptba_pkg::queue_status_t   status_o
);
  import ptba_pkg::*;

  block_t            slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign status_o.full       = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status_o.head_valid = (count_q != '0);
  assign head_o              = slots_q[rd_ptr_q];

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.head_valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (QPTR_W + 1)'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= block_i;
    end
  end

endmodule

// ===== hdl/ptba_back.sv =====
`timescale 1ns / 1ps

module ptba_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptba_pkg::block_t              head_i,
  input  ptba_pkg::queue_status_t       status_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ptba_pkg::POS_W-1:0]    out_row_o,
  output logic [ptba_pkg::POS_W-1:0]    out_column_o,
  output logic [ptba_pkg::PIX_W-1:0]    out_value_o,
  output logic                          block_last_o
);
  import ptba_pkg::*;

  phase_e           phase_q, phase_d;
  logic             valid_q, valid_d;
  logic [POS_W-1:0] row_q, row_d, col_q, col_d;
  logic [PIX_W-1:0] value_q, value_d;
  logic             last_q, last_d;
  logic             load;

  // output register may be refilled in the cycle its beat leaves
  assign load  = status_i.head_valid && (!valid_q || !out_stall_i);
  assign pop_o = load && (phase_q == PH_BOTTOM_RIGHT);

  always_comb begin
    phase_d = phase_q;
    valid_d = valid_q && out_stall_i;
    row_d   = row_q;
    col_d   = col_q;
    value_d = value_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      value_d = head_i.value;
      row_d   = head_i.row;
      col_d   = head_i.column;
      last_d  = 1'b0;
      case (phase_q)
        PH_TOP_LEFT: begin
          phase_d = PH_BOTTOM_LEFT;
        end
        PH_BOTTOM_LEFT: begin
          row_d   = {head_i.row[POS_W-1:1], 1'b1};
          phase_d = PH_TOP_RIGHT;
        end
        PH_TOP_RIGHT: begin
          col_d   = {head_i.column[POS_W-1:1], 1'b1};
          phase_d = PH_BOTTOM_RIGHT;
        end
        PH_BOTTOM_RIGHT: begin
          row_d   = {head_i.row[POS_W-1:1], 1'b1};
          col_d   = {head_i.column[POS_W-1:1], 1'b1};
          last_d  = 1'b1;
          phase_d = PH_TOP_LEFT;
        end
        default: begin
          phase_d = PH_TOP_LEFT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOP_LEFT;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    col_q   <= col_d;
    value_q <= value_d;
    last_q  <= last_d;
  end

  assign out_valid_o  = valid_q;
  assign out_row_o    = row_q;
  assign out_column_o = col_q;
  assign out_value_o  = value_q;
  assign block_last_o = last_q;

endmodule

// ===== hdl/pixelate_two_by_two_average.sv =====
`timescale 1ns / 1ps
// channel   handshake                 payload
// ------    ---------                 -------
// pixel in  in_valid_i / in_stall_o   pixel_value_i
// result    out_valid_o / out_stall_i out_row_o, out_column_o, out_value_o, block_last_o
// config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One pixel may enter every cycle while in_stall_o is low; the block result leaves over four
// output beats, so on odd rows the sustained input rate is set by the single output register.
// Result passes from the odd-row, odd-column pixel through the queue, then the output reg.
// in_stall_o rises only when the two-entry block queue is full.
// Reset sets width and height to 512 and restarts the frame; the line store is not cleared.

module pixelate_two_by_two_average #(
  parameter int MAX_WIDTH  = ptba_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ptba_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ptba_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [ptba_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ptba_pkg::PIX_W-1:0]       pixel_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ptba_pkg::POS_W-1:0]       out_row_o,
  output logic [ptba_pkg::POS_W-1:0]       out_column_o,
  output logic [ptba_pkg::PIX_W-1:0]       out_value_o,
  output logic                             block_last_o
);
  import ptba_pkg::*;

  logic          pix_accept, push, pop;
  block_t        new_block, head_block;
  queue_status_t q_status;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_status.full;
  assign pix_accept  = in_valid_i && !in_stall_o;

  ptba_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pix_accept_i  (pix_accept),
    .pixel_value_i (pixel_value_i),
    .push_o        (push),
    .block_o       (new_block)
  );

  ptba_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .block_i  (new_block),
    .pop_i    (pop),
    .head_o   (head_block),
    .status_o (q_status)
  );

  ptba_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_block),
    .status_i     (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_row_o    (out_row_o),
    .out_column_o (out_column_o),
    .out_value_o  (out_value_o),
    .block_last_o (block_last_o)
  );

endmodule
